### hdl/assert_macros.svh
// Assertion macros used by overflow_free_mean to check its own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Condition a implies condition c in the same cycle.
`define OFM_ASSERT_IMP(lbl, a, c) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (a) |-> (c)) \
        else $error("implication check failed");
// Condition a implies condition c in the next cycle.
`define OFM_ASSERT_NXT(lbl, a, c) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (a) |=> (c)) \
        else $error("next-cycle check failed");
`else
`define OFM_ASSERT_IMP(lbl, a, c)
`define OFM_ASSERT_NXT(lbl, a, c)
`endif
`endif

### hdl/ofm_pkg.sv
// Types and constants for the overflow-free mean block.
package ofm_pkg;
    localparam int VAL_W      = 64;
    localparam int CNT_IN_W   = 32;
    localparam int DIV_STEPS  = 64;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_EMIT
    } ofm_state_t;

    typedef struct packed {
        logic fold;
        logic clear;
    } ofm_acc_ctl_t;
endpackage

### hdl/ofm_div_cell.sv
// One restoring-division cell: produces one quotient bit per pass.
module ofm_div_cell #(
    parameter int COUNT_WIDTH = 32
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   valid_in,
    input  logic [COUNT_WIDTH-1:0] rem_in,
    input  logic [63:0]            quo_in,
    input  logic [COUNT_WIDTH-1:0] divisor,
    output logic                   valid_out,
    output logic [COUNT_WIDTH-1:0] rem_out,
    output logic [63:0]            quo_out
);
    import ofm_pkg::*;

    logic                   valid_reg;
    logic [COUNT_WIDTH-1:0] rem_reg, rem_next;
    logic [63:0]            quo_reg, quo_next;
    logic [COUNT_WIDTH:0]   trial;
    logic [COUNT_WIDTH:0]   diff;
    logic                   take;

    // Shift in the next dividend bit and try to subtract the divisor
    always_comb begin
        trial    = {rem_in, quo_in[VAL_W-1]};
        diff     = trial - {1'b0, divisor};
        take     = (trial >= {1'b0, divisor});
        rem_next = take ? diff[COUNT_WIDTH-1:0] : trial[COUNT_WIDTH-1:0];
        quo_next = {quo_in[VAL_W-2:0], take};
    end

    // Advance the valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_in;
        end
    end

    // Hand the partial result to the next cell
    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign valid_out = valid_reg;
    assign rem_out   = rem_reg;
    assign quo_out   = quo_reg;
endmodule

### hdl/ofm_accum.sv
// Running mean and remainder accumulator with carry on remainder wrap.
module ofm_accum #(
    parameter int COUNT_WIDTH = 32
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  ofm_pkg::ofm_acc_ctl_t  ctl,
    input  logic [63:0]            quo,
    input  logic [COUNT_WIDTH-1:0] part,
    input  logic [COUNT_WIDTH-1:0] cnt,
    output logic [63:0]            mean
);
    import ofm_pkg::*;

    logic [VAL_W-1:0]       mean_reg, mean_next;
    logic [COUNT_WIDTH-1:0] rem_reg, rem_next;
    logic [COUNT_WIDTH-1:0] gap;
    logic                   wrap;

    // Fold one quotient and remainder into the running state, or clear it
    always_comb begin
        gap       = cnt - part;
        wrap      = (rem_reg >= gap);
        mean_next = mean_reg;
        rem_next  = rem_reg;
        if (ctl.clear) begin
            mean_next = '0;
            rem_next  = '0;
        end else if (ctl.fold) begin
            mean_next = mean_reg + quo + {{(VAL_W-1){1'b0}}, wrap};
            rem_next  = wrap ? (rem_reg - gap) : (rem_reg + part);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mean_reg <= '0;
            rem_reg  <= '0;
        end else begin
            mean_reg <= mean_next;
            rem_reg  <= rem_next;
        end
    end

    assign mean = mean_reg;
endmodule

### hdl/overflow_free_mean.sv
// Timing: a present item is folded as it leaves the chain of 64 divider cells; the set's
// result is loaded in the emit state, after that fold or a last item that is not folded, once
// the output register is free. Throughput: one item at a time; a new item is taken only in the
// idle state, once a present item has left the chain and a set's result has been loaded.
// Reset: synchronous active-low aresetn clears the controller, chain valids and running state.
module overflow_free_mean #(
    parameter int COUNT_WIDTH = 32
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [159:0]  s_tdata,   // deadline[63:0], set_count[95:64], now_time[159:96]
    input  logic [0:0]    s_tuser,   // present[0]
    input  logic          s_tlast,
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [63:0]   m_tdata,   // mean[63:0]
    output logic [0:0]    m_tuser    // was_empty[0]
);
    import ofm_pkg::*;
    `include "assert_macros.svh"

    ofm_state_t             state_reg, state_next;
    logic [COUNT_WIDTH-1:0] cnt_reg;
    logic [VAL_W-1:0]       now_reg;
    logic                   last_reg;
    logic                   m_tvalid_reg;
    logic [VAL_W-1:0]       mean_out_reg;
    logic                   empty_out_reg;

    logic [VAL_W-1:0]       cnt_wide;
    logic [COUNT_WIDTH-1:0] in_cnt;
    logic                   s_fire, foldable, start, out_free, emit_fire;
    ofm_acc_ctl_t           acc_ctl;
    logic [VAL_W-1:0]       acc_mean;

    logic                   cell_v [0:DIV_STEPS];
    logic [COUNT_WIDTH-1:0] cell_r [0:DIV_STEPS];
    logic [VAL_W-1:0]       cell_q [0:DIV_STEPS];
    logic [DIV_STEPS-1:0]   chain_busy;

    // Mask the incoming count to the configured width
    assign cnt_wide = {{(VAL_W-CNT_IN_W){1'b0}}, s_tdata[95:64]};
    assign in_cnt   = cnt_wide[COUNT_WIDTH-1:0];
    assign s_fire   = s_tvalid && s_tready;
    assign foldable = s_tuser[0] && (in_cnt != '0);
    assign out_free = !m_tvalid_reg || m_tready;

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    if (foldable) begin
                        state_next = ST_DIV;
                    end else if (s_tlast) begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_DIV: begin
                if (cell_v[DIV_STEPS]) begin
                    state_next = last_reg ? ST_EMIT : ST_IDLE;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Controller outputs
    always_comb begin
        s_tready      = (state_reg == ST_IDLE);
        start         = s_fire && foldable;
        emit_fire     = (state_reg == ST_EMIT) && out_free;
        acc_ctl.fold  = cell_v[DIV_STEPS];
        acc_ctl.clear = emit_fire;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Hold the item's sideband while it is divided
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            cnt_reg  <= in_cnt;
            now_reg  <= s_tdata[159:96];
            last_reg <= s_tlast;
        end
    end

    // Divider chain
    assign cell_v[0] = start;
    assign cell_r[0] = '0;
    assign cell_q[0] = s_tdata[63:0];

    for (genvar i = 0; i < DIV_STEPS; i++) begin : g_cell
        ofm_div_cell #(.COUNT_WIDTH(COUNT_WIDTH)) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .valid_in  (cell_v[i]),
            .rem_in    (cell_r[i]),
            .quo_in    (cell_q[i]),
            .divisor   (i == 0 ? in_cnt : cnt_reg),
            .valid_out (cell_v[i+1]),
            .rem_out   (cell_r[i+1]),
            .quo_out   (cell_q[i+1])
        );
        assign chain_busy[i] = cell_v[i+1];
    end

    ofm_accum #(.COUNT_WIDTH(COUNT_WIDTH)) u_accum (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (acc_ctl),
        .quo     (cell_q[DIV_STEPS]),
        .part    (cell_r[DIV_STEPS]),
        .cnt     (cnt_reg),
        .mean    (acc_mean)
    );

    // Output register: load on emit, drop after transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (emit_fire) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit_fire) begin
            empty_out_reg <= (cnt_reg == '0);
            mean_out_reg  <= (cnt_reg == '0) ? now_reg : acc_mean;
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = mean_out_reg;
    assign m_tuser[0] = empty_out_reg;

    `OFM_ASSERT_IMP(a_one_in_chain, 1'b1, $countones(chain_busy) <= 1)
    `OFM_ASSERT_IMP(a_chain_in_div, chain_busy != '0, state_reg == ST_DIV)
    `OFM_ASSERT_NXT(a_last_fold_emits, cell_v[DIV_STEPS] && last_reg, state_reg == ST_EMIT)
endmodule

### test/tb.sv
// Self-checking testbench for the overflow-free mean block.
`timescale 1ns / 1ps
module tb;
    import ofm_pkg::*;

    localparam int CW         = 32;
    localparam int WDOG_LIMIT = 20000;
    localparam int TAIL_CYC   = 140;

    // Set items as driven on the input channel
    typedef struct {
        logic [63:0] deadline;
        logic        present;
        logic [31:0] set_count;
        logic [63:0] now_time;
        logic        last;
    } set_item_t;

    // Mean results as seen on the output channel
    typedef struct {
        logic [63:0] mean;
        logic        was_empty;
    } mean_res_t;

    // Directed row: item plus optional typed-in result
    typedef struct {
        set_item_t   item;
        logic        has_fixed;
        mean_res_t   fixed;
    } dir_row_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [159:0] s_tdata = '0;
    logic [0:0]   s_tuser = '0;
    logic         s_tlast = 1'b0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [63:0]  m_tdata;
    logic [0:0]   m_tuser;

    overflow_free_mean #(.COUNT_WIDTH(CW)) DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    always #2 aclk = ~aclk;

    mean_res_t   pending_means[$];
    logic [63:0] acc_mean;
    logic [CW-1:0] acc_rem;
    int          err_cnt = 0;
    int          src_idle_pct = 8;
    int          snk_idle_pct = 48;
    bit          snk_hold = 1'b0;
    int          quiet_cyc = 0;
    dir_row_t    dir_rows[$];

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        err_cnt++;
    endtask

    // Advance the predicted running state by one item; queue a result on last
    task automatic predict_mean(input set_item_t it, input bit use_fixed,
                                input mean_res_t fixed);
        logic [63:0] cnt;
        logic [63:0] part;
        logic [63:0] gap;
        mean_res_t   res;
        cnt = {32'd0, it.set_count} & ((64'd1 << CW) - 64'd1);
        if (it.present && cnt != 0) begin
            part = it.deadline % cnt;
            gap = (cnt - part) & ((64'd1 << CW) - 64'd1);
            acc_mean += it.deadline / cnt;
            if ({32'd0, acc_rem} >= gap) begin
                acc_mean += 64'd1;
                acc_rem = acc_rem - gap[CW-1:0];
            end else begin
                acc_rem = acc_rem + part[CW-1:0];
            end
        end
        if (it.last) begin
            if (cnt == 0) begin
                res.mean = it.now_time;
                res.was_empty = 1'b1;
            end else begin
                res.mean = acc_mean;
                res.was_empty = 1'b0;
            end
            if (use_fixed && (res.mean !== fixed.mean || res.was_empty !== fixed.was_empty))
                report_mismatch("predictor disagrees with typed-in result");
            pending_means.push_back(use_fixed ? fixed : res);
            acc_mean = '0;
            acc_rem = '0;
        end
    endtask

    // Drive one item, random gaps before it, hold until the transfer
    task automatic send_item(input set_item_t it, input bit use_fixed, input mean_res_t fixed);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {it.now_time, it.set_count, it.deadline};
        s_tuser <= it.present;
        s_tlast <= it.last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_mean(it, use_fixed, fixed);
        @(negedge aclk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic set_item_t mk_item(input logic [63:0] d, input logic p,
                                          input logic [31:0] c, input logic [63:0] n,
                                          input logic l);
        set_item_t it;
        it.deadline = d; it.present = p; it.set_count = c; it.now_time = n; it.last = l;
        return it;
    endfunction

    function automatic void add_row(input set_item_t it, input bit has_fixed,
                                    input logic [63:0] m, input logic e);
        dir_row_t r;
        r.item = it; r.has_fixed = has_fixed; r.fixed.mean = m; r.fixed.was_empty = e;
        dir_rows.push_back(r);
    endfunction

    // Send one well-formed set, sometimes bent out of shape
    task automatic send_rand_set();
        int          n;
        int          npres;
        logic [31:0] cnt;
        logic [63:0] now_t;
        set_item_t   it;
        n = $urandom_range(1, 6);
        case ($urandom_range(9))
            0: cnt = 32'd0;
            1: cnt = 32'hFFFF_FFFF - $urandom_range(3);
            2: cnt = $urandom();
            default: cnt = $urandom_range(1, n);
        endcase
        npres = 0;
        now_t = rand64();
        for (int i = 0; i < n; i++) begin
            it.deadline = ($urandom_range(3) == 0) ? rand64() : (64'hFFFF_FFFF_FFFF_0000
                          | {48'd0, 16'($urandom())});
            if ($urandom_range(1)) it.deadline = rand64();
            it.present = (npres < cnt) ? ($urandom_range(3) != 0) : ($urandom_range(7) == 0);
            if (it.present) npres++;
            it.set_count = ($urandom_range(19) == 0) ? $urandom_range(0, 7) : cnt;
            it.now_time = now_t;
            it.last = (i == n - 1);
            send_item(it, 1'b0, '{default: '0});
        end
    endtask

    // Check each result transfer against the oldest expectation
    always @(posedge aclk) begin
        mean_res_t exp_r;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_means.size() == 0) begin
                report_mismatch("result with no expectation");
            end else begin
                exp_r = pending_means.pop_front();
                if (m_tdata !== exp_r.mean)
                    report_mismatch($sformatf("mean %h exp %h", m_tdata, exp_r.mean));
                if (m_tuser[0] !== exp_r.was_empty)
                    report_mismatch($sformatf("was_empty %b exp %b", m_tuser[0],
                                              exp_r.was_empty));
            end
        end
    end

    // Receiver readiness, with random stalls and a forced hold-off
    always @(negedge aclk) begin
        m_tready <= !snk_hold && ($urandom_range(99) >= snk_idle_pct);
    end

    // Watchdog on cycles with no transfer
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cyc <= 0;
        else quiet_cyc <= quiet_cyc + 1;
        if (quiet_cyc >= WDOG_LIMIT) begin
            $display("** overflow_free_mean: FAILED **");
            $finish;
        end
    end

    // Long receiver hold-off while the sender keeps offering items
    initial begin
        wait (aresetn);
        repeat (300) @(posedge aclk);
        snk_hold = 1'b1;
        repeat (1500) @(negedge aclk);
        snk_hold = 1'b0;
    end

    initial begin
        logic [63:0] max64;
        max64 = '1;
        acc_mean = '0;
        acc_rem = '0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: extremes, empty set, zero count, skipped items, count changes
        add_row(mk_item(max64, 1'b1, 32'd1, 64'd5, 1'b1), 1'b1, max64, 1'b0);
        add_row(mk_item(64'd0, 1'b1, 32'd1, max64, 1'b1), 1'b1, 64'd0, 1'b0);
        add_row(mk_item(64'd7, 1'b1, 32'd0, 64'h1234, 1'b1), 1'b1, 64'h1234, 1'b1);
        add_row(mk_item(64'd9, 1'b0, 32'd0, max64, 1'b1), 1'b1, max64, 1'b1);
        add_row(mk_item(max64, 1'b1, 32'd2, 64'd0, 1'b0), 1'b0, '0, 1'b0);
        add_row(mk_item(max64, 1'b1, 32'd2, 64'd0, 1'b1), 1'b1, max64, 1'b0);
        add_row(mk_item(max64, 1'b1, 32'd3, 64'd0, 1'b0), 1'b0, '0, 1'b0);
        add_row(mk_item(64'd1, 1'b0, 32'd3, 64'd0, 1'b0), 1'b0, '0, 1'b0);
        add_row(mk_item(max64 - 64'd1, 1'b1, 32'd3, 64'd0, 1'b0), 1'b0, '0, 1'b0);
        add_row(mk_item(max64 - 64'd2, 1'b1, 32'd3, 64'd0, 1'b1), 1'b1, max64 - 64'd1, 1'b0);
        add_row(mk_item(max64, 1'b1, 32'hFFFF_FFFF, 64'd0, 1'b0), 1'b0, '0, 1'b0);
        add_row(mk_item(max64, 1'b1, 32'hFFFF_FFFF, 64'd0, 1'b1), 1'b0, '0, 1'b0);
        add_row(mk_item(64'd10, 1'b1, 32'd0, 64'd0, 1'b0), 1'b0, '0, 1'b0);
        add_row(mk_item(64'd11, 1'b1, 32'd2, 64'd0, 1'b0), 1'b0, '0, 1'b0);
        add_row(mk_item(64'd12, 1'b1, 32'd5, 64'd0, 1'b0), 1'b0, '0, 1'b0);
        add_row(mk_item(max64, 1'b1, 32'd1, 64'd0, 1'b0), 1'b0, '0, 1'b0);
        add_row(mk_item(max64, 1'b1, 32'd1, 64'd0, 1'b1), 1'b0, '0, 1'b0);
        add_row(mk_item(64'd100, 1'b0, 32'd4, 64'hAAAA, 1'b0), 1'b0, '0, 1'b0);
        add_row(mk_item(64'd100, 1'b0, 32'd4, 64'hAAAA, 1'b1), 1'b1, 64'd0, 1'b0);
        foreach (dir_rows[i])
            send_item(dir_rows[i].item, dir_rows[i].has_fixed, dir_rows[i].fixed);

        // Random sets, three idling phases
        for (int ph = 0; ph < 3; ph++) begin
            src_idle_pct = (ph == 0) ? 8 : (ph == 1) ? 48 : 0;
            snk_idle_pct = (ph == 0) ? 48 : (ph == 1) ? 8 : 0;
            for (int k = 0; k < 70; k++) send_rand_set();
        end

        // Drop the request after the final transfer
        s_tvalid <= 1'b0;
        wait (pending_means.size() == 0);
        repeat (TAIL_CYC) @(posedge aclk);
        if (err_cnt == 0) begin
            $display("** overflow_free_mean: PASSED **");
        end else begin
            $display("** overflow_free_mean: FAILED **");
        end
        $finish;
    end
endmodule
